[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of the console block.
// Each macro wraps one clocked concurrent assertion with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("console checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("console checker: next-cycle property failed");

`endif

[rtl/tcw_pkg.sv]
// Package of the text console writer: request and result types, opcodes,
// sequencer states and fixed cell constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] char_byte;
		logic [4:0] row_index;
		logic [6:0] col_index;
		logic [3:0] fg_color;
		logic [3:0] bg_color;
	} tcw_in_t;

	typedef struct packed {
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic       scrolled;
	} tcw_out_t;

	typedef struct packed {
		logic fin;
		logic busy;
	} tcw_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCROLL,
		ST_FILL,
		ST_READ,
		ST_FLUSH
	} tcw_state_t;

	localparam logic [2:0] OP_PUT    = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_CURSOR = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [7:0] CHAR_NULL    = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] ATTR_CLEAR   = 8'h07;
	localparam logic [7:0] ATTR_BLANK   = 8'h0F;

endpackage

`default_nettype wire

[rtl/tcw_screen_ram.sv]
// Screen cell memory: one write port and one read port with registered
// read data. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/tcw_engine.sv]
// Console sequencer: cursor registers, opcode decode and the sweeps that
// clear, copy and fill the screen memory. Uses tcw_pkg and tcw_screen_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcw_engine
	import tcw_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_req,
	input  wire tcw_in_t     cmd,
	output tcw_status_t      status,
	output tcw_out_t         result
);

	localparam int N  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(N);
	localparam int RW = $clog2(SCREEN_HEIGHT);
	localparam int CW = $clog2(SCREEN_WIDTH);

	tcw_state_t state_q, state_d;
	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic init_q, init_d;
	logic scroll_q, scroll_d;
	logic rd_ok_q, rd_ok_d;

	logic          wr_valid_s1, s1_valid_d;
	logic          wr_copy_s1, s1_copy_d;
	logic [AW-1:0] wr_addr_s1, s1_addr_d;
	logic [15:0]   wr_data_s1, s1_data_d;

	logic          dw_en;
	logic [AW-1:0] dw_addr;
	logic [15:0]   dw_data;
	logic          re;
	logic [AW-1:0] raddr;
	logic [15:0]   rdata;
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          fin;

	logic          row_last, col_last, in_range, is_newline;
	logic [AW-1:0] cmd_addr, cur_addr;

	assign row_last   = cur_row_q == RW'(SCREEN_HEIGHT - 1);
	assign col_last   = cur_col_q == CW'(SCREEN_WIDTH - 1);
	assign in_range   = (32'(cmd.row_index) < SCREEN_HEIGHT) &&
	                    (32'(cmd.col_index) < SCREEN_WIDTH);
	assign is_newline = cmd.char_byte == CHAR_NEWLINE;
	assign cmd_addr   = AW'(AW'(cmd.row_index) * AW'(SCREEN_WIDTH) + AW'(cmd.col_index));
	assign cur_addr   = AW'(AW'(cur_row_q) * AW'(SCREEN_WIDTH) + AW'(cur_col_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_req) begin
					case (cmd.opcode)
						OP_PUT: begin
							if (cmd.char_byte != CHAR_NULL) begin
								if (is_newline ? row_last : (row_last && col_last)) begin
									state_d = ST_SCROLL;
								end
							end
						end
						OP_CLEAR: state_d = ST_CLEAR;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR:  if (cnt_q == AW'(N - 1)) state_d = ST_FLUSH;
			ST_SCROLL: if (cnt_q == AW'(N - SCREEN_WIDTH - 1)) state_d = ST_FILL;
			ST_FILL:   if (cnt_q == AW'(N - 1)) state_d = ST_FLUSH;
			ST_READ:   state_d = ST_IDLE;
			ST_FLUSH:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cur_row_d  = cur_row_q;
		cur_col_d  = cur_col_q;
		cnt_d      = cnt_q;
		init_d     = init_q;
		scroll_d   = scroll_q;
		rd_ok_d    = rd_ok_q;
		s1_valid_d = 1'b0;
		s1_copy_d  = 1'b0;
		s1_addr_d  = cnt_q;
		s1_data_d  = {ATTR_CLEAR, CHAR_NULL};
		dw_en      = 1'b0;
		dw_addr    = cur_addr;
		dw_data    = {4'h0, cmd.fg_color, cmd.char_byte};
		re         = 1'b0;
		raddr      = cmd_addr;
		fin        = 1'b0;
		result     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_req) begin
					cnt_d    = '0;
					scroll_d = 1'b0;
					case (cmd.opcode)
						OP_PUT: begin
							fin = 1'b1;
							if (cmd.char_byte != CHAR_NULL) begin
								if (!is_newline) begin
									dw_en = 1'b1;
								end
								if (is_newline ? row_last : (row_last && col_last)) begin
									fin       = 1'b0;
									scroll_d  = 1'b1;
									cur_row_d = RW'(SCREEN_HEIGHT - 1);
									cur_col_d = '0;
								end else if (is_newline || col_last) begin
									cur_row_d = cur_row_q + 1'b1;
									cur_col_d = '0;
								end else begin
									cur_col_d = cur_col_q + 1'b1;
								end
							end
						end
						OP_WRITE: begin
							fin     = 1'b1;
							dw_en   = in_range;
							dw_addr = cmd_addr;
							dw_data = {cmd.bg_color, cmd.fg_color, cmd.char_byte};
						end
						OP_CURSOR: begin
							fin = 1'b1;
							if (in_range) begin
								cur_row_d = RW'(cmd.row_index);
								cur_col_d = CW'(cmd.col_index);
							end
						end
						OP_CLEAR: begin
							fin = 1'b0;
						end
						OP_READ: begin
							re      = 1'b1;
							rd_ok_d = in_range;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_CLEAR: begin
				s1_valid_d = 1'b1;
				cnt_d      = cnt_q + 1'b1;
			end
			ST_SCROLL: begin
				re         = 1'b1;
				raddr      = cnt_q + AW'(SCREEN_WIDTH);
				s1_valid_d = 1'b1;
				s1_copy_d  = 1'b1;
				cnt_d      = cnt_q + 1'b1;
			end
			ST_FILL: begin
				s1_valid_d = 1'b1;
				s1_data_d  = {ATTR_BLANK, CHAR_NULL};
				cnt_d      = cnt_q + 1'b1;
			end
			ST_READ: begin
				fin = 1'b1;
				if (rd_ok_q) begin
					result.cell_char = rdata[7:0];
					result.cell_attr = rdata[15:8];
				end
			end
			ST_FLUSH: begin
				fin             = !init_q;
				init_d          = 1'b0;
				result.scrolled = scroll_q;
			end
			default: fin = 1'b0;
		endcase
		result.cursor_row = 5'(cur_row_d);
		result.cursor_col = 7'(cur_col_d);
	end

	// Sweep writes go through the stage register so that a copy lands in the
	// cycle after its read; direct writes only occur while the stage is empty.
	assign we    = wr_valid_s1 || dw_en;
	assign waddr = wr_valid_s1 ? wr_addr_s1 : dw_addr;
	assign wdata = wr_valid_s1 ? (wr_copy_s1 ? rdata : wr_data_s1) : dw_data;

	assign status.fin  = fin;
	assign status.busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cnt_q       <= '0;
			init_q      <= 1'b1;
			scroll_q    <= 1'b0;
			rd_ok_q     <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_row_q   <= cur_row_d;
			cur_col_q   <= cur_col_d;
			cnt_q       <= cnt_d;
			init_q      <= init_d;
			scroll_q    <= scroll_d;
			rd_ok_q     <= rd_ok_d;
			wr_valid_s1 <= s1_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		wr_copy_s1 <= s1_copy_d;
		wr_addr_s1 <= s1_addr_d;
		wr_data_s1 <= s1_data_d;
	end

	tcw_screen_ram #(
		.DEPTH (N),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer, top level: request and result channels with the
// result register and a one-entry hold stage. Uses tcw_pkg and tcw_engine.
//
// The block keeps a SCREEN_WIDTH x SCREEN_HEIGHT text screen in one memory
// and returns one result per request. Put char, write cell, set cursor and
// no-op requests finish in the accepting cycle; read cell finishes in the
// cycle after, as the memory's read data is registered. Clear runs through
// the accepting cycle, W*H clear steps and one drain step, and a put char or
// newline that scrolls through the accepting cycle, W*H-W copy steps, W fill
// steps and one drain step, all paced by the single memory write port.
// After reset all W*H cells are cleared, with a drain step, before the first
// request is taken. A request is taken while an earlier result still waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_stall,
	input  wire tcw_in_t cmd,
	output logic         res_valid,
	input  wire logic    res_stall,
	output tcw_out_t     res
);

	tcw_status_t status;
	tcw_out_t    result;
	tcw_out_t    pend_q;
	logic        pend_valid_q;
	logic        res_valid_q;
	tcw_out_t    res_q;
	logic        cmd_req;
	logic        out_take;
	logic        out_free;

	assign cmd_stall = status.busy || pend_valid_q;
	assign cmd_req   = cmd_valid && !cmd_stall;
	assign out_take  = res_valid_q && !res_stall;
	assign out_free  = !res_valid_q || out_take;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q && out_free) begin
				res_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (status.fin) begin
				if (out_free) begin
					res_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_free) begin
			res_q <= pend_q;
		end else if (status.fin) begin
			if (out_free) begin
				res_q <= result;
			end else begin
				pend_q <= result;
			end
		end
	end

	tcw_engine #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_req (cmd_req),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

endmodule

`default_nettype wire

[rtl/tcw_checker.sv]
// Port-level checker of the text console writer and its bind to the top.
// Uses tcw_pkg and the macros of assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     res_valid,
	input wire logic     res_stall,
	input wire tcw_out_t res
);

	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))
	`ASSERT_IMPL(a_cursor_range, clk, arst_n, res_valid, (32'(res.cursor_col) < SCREEN_WIDTH) && (32'(res.cursor_row) < SCREEN_HEIGHT))
	`ASSERT_IMPL(a_scroll_home, clk, arst_n, res_valid && res.scrolled, (res.cursor_col == 7'd0) && (res.cursor_row == 5'(SCREEN_HEIGHT - 1)) && (res.cell_char == 8'd0))

endmodule

bind text_console_writer tcw_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire

[test/text_console_writer_tb.sv]
// Self-checking testbench for text_console_writer: a directed table and random requests,
// each result checked against a screen and cursor predictor kept in the bench.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb
	import tcw_pkg::*;
();

	localparam int SCREEN_W = 80;
	localparam int SCREEN_H = 25;
	localparam int CELLS = SCREEN_W * SCREEN_H;
	localparam int RANDOM_CMDS = 500;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IN_W = $bits(tcw_in_t);

	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct {
		tcw_in_t  req;
		bit       typed;
		tcw_out_t want;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_stall;
	tcw_in_t  cmd = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	tcw_out_t res;

	logic [15:0] screen_mem [0:CELLS-1];
	int unsigned cur_row;
	int unsigned cur_col;
	int unsigned last_wr_row;
	int unsigned last_wr_col;

	tcw_out_t  due_status [$];
	stim_row_t directed_rows [$];

	bit quiet = 1'b0;
	bit hold_off_req = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int reqs_taken = 0;
	int results_seen = 0;
	int scrolls_seen = 0;
	int clears_sent = 0;
	int reads_sent = 0;

	text_console_writer #(
		.SCREEN_WIDTH(SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic tcw_in_t mk_req(logic [2:0] op, int ch, int row, int col, int fg, int bg);
		tcw_in_t r;
		r.opcode = op;
		r.char_byte = ch[7:0];
		r.row_index = row[4:0];
		r.col_index = col[6:0];
		r.fg_color = fg[3:0];
		r.bg_color = bg[3:0];
		return r;
	endfunction

	function automatic tcw_out_t mk_res(int row, int col, int ch, int attr, int scr);
		tcw_out_t r;
		r.cursor_row = row[4:0];
		r.cursor_col = col[6:0];
		r.cell_char = ch[7:0];
		r.cell_attr = attr[7:0];
		r.scrolled = scr[0];
		return r;
	endfunction

	function automatic void scroll_screen();
		for (int k = 0; k < CELLS - SCREEN_W; k++)
			screen_mem[k] = screen_mem[k + SCREEN_W];
		for (int k = CELLS - SCREEN_W; k < CELLS; k++)
			screen_mem[k] = {ATTR_BLANK, CHAR_NULL};
		cur_row = SCREEN_H - 1;
		cur_col = 0;
	endfunction

	function automatic tcw_out_t apply_console_cmd(tcw_in_t c);
		tcw_out_t r;
		bit in_range;
		int unsigned addr;
		int unsigned pos;
		r = '0;
		in_range = (c.row_index < SCREEN_H) && (c.col_index < SCREEN_W);
		addr = c.row_index * SCREEN_W + c.col_index;
		case (c.opcode)
			OP_PUT: begin
				if (c.char_byte == CHAR_NEWLINE) begin
					if (cur_row >= SCREEN_H - 1) begin
						scroll_screen();
						r.scrolled = 1'b1;
					end else begin
						cur_row++;
						cur_col = 0;
					end
				end else if (c.char_byte != CHAR_NULL) begin
					pos = cur_row * SCREEN_W + cur_col;
					screen_mem[pos] = {4'h0, c.fg_color, c.char_byte};
					if (pos + 1 >= CELLS) begin
						scroll_screen();
						r.scrolled = 1'b1;
					end else begin
						cur_row = (pos + 1) / SCREEN_W;
						cur_col = (pos + 1) % SCREEN_W;
					end
				end
			end
			OP_WRITE: begin
				if (in_range)
					screen_mem[addr] = {c.bg_color, c.fg_color, c.char_byte};
			end
			OP_CURSOR: begin
				if (in_range) begin
					cur_row = 32'(c.row_index);
					cur_col = 32'(c.col_index);
				end
			end
			OP_CLEAR: begin
				for (int k = 0; k < CELLS; k++)
					screen_mem[k] = {ATTR_CLEAR, CHAR_NULL};
			end
			OP_READ: begin
				if (in_range) begin
					r.cell_char = screen_mem[addr][7:0];
					r.cell_attr = screen_mem[addr][15:8];
				end
			end
			default: ;
		endcase
		r.cursor_row = cur_row[4:0];
		r.cursor_col = cur_col[6:0];
		return r;
	endfunction

	function automatic int pick_row();
		return ($urandom_range(99) < 85) ? $urandom_range(SCREEN_H - 1) : $urandom_range(31);
	endfunction

	function automatic int pick_col();
		return ($urandom_range(99) < 85) ? $urandom_range(SCREEN_W - 1) : $urandom_range(127);
	endfunction

	function automatic tcw_in_t gen_cmd();
		tcw_in_t c;
		int roll;
		int ch;
		c = mk_req(OP_PUT, $urandom_range(255), $urandom_range(31), $urandom_range(127),
			$urandom_range(15), $urandom_range(15));
		roll = $urandom_range(99);
		if (roll < 50) begin
			ch = $urandom_range(99);
			if (ch < 5)
				c.char_byte = CHAR_NEWLINE;
			else if (ch < 8)
				c.char_byte = CHAR_NULL;
		end else if (roll < 62) begin
			c.opcode = OP_WRITE;
			c.row_index = 5'(pick_row());
			c.col_index = 7'(pick_col());
			last_wr_row = 32'(c.row_index);
			last_wr_col = 32'(c.col_index);
		end else if (roll < 74) begin
			c.opcode = OP_CURSOR;
			ch = $urandom_range(99);
			if (ch < 12) begin
				c.row_index = 5'(SCREEN_H - 1);
				c.col_index = 7'($urandom_range(SCREEN_W - 1, SCREEN_W - 10));
			end else begin
				c.row_index = 5'(pick_row());
				c.col_index = 7'(pick_col());
			end
		end else if (roll < 76) begin
			c.opcode = OP_CLEAR;
		end else if (roll < 96) begin
			c.opcode = OP_READ;
			ch = $urandom_range(99);
			if (ch < 40) begin
				c.row_index = 5'(last_wr_row);
				c.col_index = 7'(last_wr_col);
			end else if (ch < 55 && cur_col > 0) begin
				c.row_index = 5'(cur_row);
				c.col_index = 7'(cur_col - 1);
			end else begin
				c.row_index = 5'(pick_row());
				c.col_index = 7'(pick_col());
			end
		end else begin
			c.opcode = 3'($urandom_range(OP_SPARE7, OP_SPARE5));
		end
		return c;
	endfunction

	task automatic rest_cmd(int n);
		logic [IN_W-1:0] junk;
		repeat (n) begin
			@(negedge clk);
			junk = IN_W'($urandom);
			cmd_valid <= 1'b0;
			cmd <= junk;
		end
	endtask

	task automatic offer_cmd(tcw_in_t c, bit typed, tcw_out_t want);
		tcw_out_t got;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		got = apply_console_cmd(c);
		due_status.push_back(typed ? want : got);
		reqs_taken++;
		if (c.opcode == OP_CLEAR)
			clears_sent++;
		if (c.opcode == OP_READ)
			reads_sent++;
		if (!quiet && $urandom_range(99) < 37)
			rest_cmd($urandom_range(1, 5));
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		tcw_out_t want;
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			results_seen++;
			if (res.scrolled === 1'b1)
				scrolls_seen++;
			if (due_status.size() == 0) begin
				$error("result with no request pending: %h", res);
				errors++;
			end else begin
				want = due_status.pop_front();
				check_field("cursor_row", 32'(want.cursor_row), 32'(res.cursor_row));
				check_field("cursor_col", 32'(want.cursor_col), 32'(res.cursor_col));
				check_field("cell_char", 32'(want.cell_char), 32'(res.cell_char));
				check_field("cell_attr", 32'(want.cell_attr), 32'(res.cell_attr));
				check_field("scrolled", 32'(want.scrolled), 32'(res.scrolled));
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (quiet) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(99) < 37);
			end
		end
	end

	initial begin
		#80_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int directed_count;
		for (int k = 0; k < CELLS; k++)
			screen_mem[k] = {ATTR_CLEAR, CHAR_NULL};
		cur_row = 0;
		cur_col = 0;
		last_wr_row = 0;
		last_wr_col = 0;

		directed_rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, ATTR_CLEAR, 0)});
		directed_rows.push_back('{mk_req(OP_READ, 0, 24, 79, 15, 15), 1'b1,
			mk_res(0, 0, 0, ATTR_CLEAR, 0)});
		directed_rows.push_back('{mk_req(OP_READ, 255, 31, 127, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_PUT, 8'h41, 0, 0, 15, 0), 1'b1,
			mk_res(0, 1, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_PUT, CHAR_NULL, 31, 127, 15, 15), 1'b1,
			mk_res(0, 1, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 1, 8'h41, 8'h0F, 0)});
		directed_rows.push_back('{mk_req(OP_PUT, 255, 0, 0, 0, 15), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_PUT, CHAR_NEWLINE, 0, 0, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_WRITE, 255, 24, 79, 15, 15), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_READ, 0, 24, 79, 0, 0), 1'b1,
			mk_res(1, 0, 255, 255, 0)});
		directed_rows.push_back('{mk_req(OP_WRITE, 8'h55, 25, 0, 3, 4), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_WRITE, 8'h55, 0, 80, 3, 4), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_CURSOR, 0, 25, 0, 0, 0), 1'b1,
			mk_res(1, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_CURSOR, 0, 0, 127, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_CURSOR, 0, 24, 79, 0, 0), 1'b1,
			mk_res(24, 79, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_PUT, 8'h5A, 0, 0, 14, 0), 1'b1,
			mk_res(24, 0, 0, 0, 1)});
		directed_rows.push_back('{mk_req(OP_READ, 0, 23, 79, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_READ, 0, 24, 0, 0, 0), 1'b1,
			mk_res(24, 0, 0, ATTR_BLANK, 0)});
		directed_rows.push_back('{mk_req(OP_PUT, CHAR_NEWLINE, 0, 0, 0, 0), 1'b1,
			mk_res(24, 0, 0, 0, 1)});
		directed_rows.push_back('{mk_req(OP_SPARE5, 255, 31, 127, 15, 15), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_SPARE7, 0, 3, 5, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1,
			mk_res(24, 0, 0, 0, 0)});
		directed_rows.push_back('{mk_req(OP_READ, 0, 22, 79, 0, 0), 1'b1,
			mk_res(24, 0, 0, ATTR_CLEAR, 0)});
		directed_rows.push_back('{mk_req(OP_CURSOR, 0, 0, 0, 0, 0), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_WRITE, CHAR_NEWLINE, 0, 0, 3, 12), 1'b0, '0});
		directed_rows.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0), 1'b0, '0});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_cmd(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		directed_count = reqs_taken;

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			quiet = (i >= 150 && i < 250);
			if (i == 60)
				hold_off_req = 1'b1;
			if (i == 320) begin
				rest_cmd(1);
				while (due_status.size() != 0)
					@(posedge clk);
			end
			offer_cmd(gen_cmd(), 1'b0, '0);
		end

		rest_cmd(1);
		while (due_status.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Run covered %0d requests (%0d directed) and %0d results,", reqs_taken,
			directed_count, results_seen);
		$display("including %0d scrolls, %0d clears and %0d cell reads.", scrolls_seen,
			clears_sent, reads_sent);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
